// ----- rtl/mse_pkg.sv -----
`timescale 1ns / 1ps

package mse_pkg;

   // data memory geometry
   localparam int DATA_DEPTH = 1024;
   localparam int DADDR_W    = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;
   // index range check is done one bit wider than the 16-bit immediate
   localparam int LIMIT_W    = 17;

   // decoded request queue
   localparam int Q_DEPTH = 2;
   localparam int Q_AW    = $clog2(Q_DEPTH);

   // instruction encoding
   localparam logic [31:0] SYSCALL_WORD = 32'h0000000C;
   localparam logic [5:0]  OP_RTYPE     = 6'd0;
   localparam logic [5:0]  OP_ADDIU     = 6'd9;
   localparam logic [5:0]  OP_LW        = 6'd35;
   localparam logic [5:0]  OP_SW        = 6'd43;
   localparam logic [5:0]  FN_ADDU      = 6'd33;
   localparam logic [5:0]  FN_SLT       = 6'd42;
   localparam logic [31:0] V0_HALT      = 32'd10;
   localparam logic [31:0] V0_READ      = 32'd5;
   localparam logic [4:0]  REG_ZERO     = 5'd0;
   localparam logic [4:0]  REG_V0       = 5'd2;
   localparam logic [4:0]  REG_GP       = 5'd28;

   // configuration register indexes
   localparam logic CSR_GP_INIT    = 1'b0;
   localparam logic CSR_DATA_WORDS = 1'b1;
   localparam logic [10:0] DATA_WORDS_RST = 11'd1024;

   // operation class picked by the front end
   typedef enum logic [2:0] {
      K_NOP,
      K_ADDU,
      K_SLT,
      K_ADDIU,
      K_LW,
      K_SW,
      K_SYS,
      K_BAD
   } kind_type;

   // decoded request handed from front to back
   typedef struct packed {
      kind_type    kind;
      logic [4:0]  ra;      // first read port (rs, or v0 for syscall)
      logic [4:0]  rb;      // second read port (rt)
      logic [4:0]  dst;     // destination register
      logic [15:0] imm;
      logic        mem_ok;  // memory in use is not empty
      logic [31:0] rd_val;
   } op_type;

   // request payload, instruction in the low bits
   typedef struct packed {
      logic [31:0] read_value;
      logic [31:0] instruction;
   } req_type;

   // response payload, reg_written in bit 0
   typedef struct packed {
      logic        bad_index;
      logic        halted;
      logic [31:0] print_value;
      logic        print_valid;
      logic        mem_written;
      logic [31:0] reg_value;
      logic [4:0]  reg_index;
      logic        reg_written;
   } rsp_type;

   localparam int REQ_W    = $bits(req_type);
   localparam int RSP_BITS = $bits(rsp_type);
   localparam int RSP_W    = ((RSP_BITS + 7) / 8) * 8;

endpackage

// ----- rtl/mse_ram.sv -----
`timescale 1ns / 1ps

module mse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // single write port, registered read returning the old word on a collision
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/mse_front.sv -----
`timescale 1ns / 1ps

module mse_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  mse_pkg::req_type     req_data,
   input  logic [10:0]          data_words,
   input  logic                 hold_off,
   output logic                 head_vld,
   output mse_pkg::op_type      head,
   input  logic                 pop
);
   import mse_pkg::*;

   logic [5:0]         opc;
   logic [5:0]         fn;
   logic [15:0]        imm;
   logic [LIMIT_W-1:0] dw_ext;
   logic [LIMIT_W-1:0] limit;
   logic               idx_bad;
   op_type             dec;
   logic               push;

   op_type             q_ff [Q_DEPTH];
   logic [Q_AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [Q_AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [Q_AW:0]      cnt_ff, cnt_in;

   // memory in use, capped at the physical depth
   always_comb begin
      dw_ext  = LIMIT_W'(data_words);
      limit   = (dw_ext > LIMIT_W'(DATA_DEPTH)) ? LIMIT_W'(DATA_DEPTH) : dw_ext;
      idx_bad = LIMIT_W'(imm) >= limit;
   end

   assign opc = req_data.instruction[31:26];
   assign fn  = req_data.instruction[5:0];
   assign imm = req_data.instruction[15:0];

   // classify the instruction
   always_comb begin
      dec.ra     = req_data.instruction[25:21];
      dec.rb     = req_data.instruction[20:16];
      dec.dst    = req_data.instruction[20:16];
      dec.imm    = imm;
      dec.mem_ok = limit != '0;
      dec.rd_val = req_data.read_value;
      dec.kind   = K_NOP;
      priority if (req_data.instruction == SYSCALL_WORD) begin
         dec.kind = K_SYS;
         dec.ra   = REG_V0;
      end else if (opc == OP_RTYPE) begin
         dec.dst = req_data.instruction[15:11];
         if (fn == FN_ADDU) begin
            dec.kind = K_ADDU;
         end else if (fn == FN_SLT) begin
            dec.kind = K_SLT;
         end
      end else if (opc == OP_ADDIU) begin
         dec.kind = K_ADDIU;
      end else if (opc == OP_LW || opc == OP_SW) begin
         if (idx_bad) begin
            dec.kind = K_BAD;
         end else begin
            dec.kind = (opc == OP_LW) ? K_LW : K_SW;
         end
      end
   end

   // request queue towards the back end
   assign req_tready = (cnt_ff != (Q_AW+1)'(Q_DEPTH)) && !hold_off;
   assign push       = req_tvalid && req_tready;
   assign head_vld   = cnt_ff != '0;
   assign head       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + (Q_AW+1)'(push) - (Q_AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= dec;
      end
   end

endmodule

// ----- rtl/mse_back.sv -----
`timescale 1ns / 1ps

module mse_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_vld,
   input  mse_pkg::op_type      head,
   output logic                 pop,
   input  logic [31:0]          gp_init,
   input  logic                 gp_wr,
   output logic                 clr_busy,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output mse_pkg::rsp_type     rsp_data
);
   import mse_pkg::*;

   // execute stage
   logic               x_vld_ff, x_vld_in;
   op_type             x_op_ff;
   logic               a_vld_ff, b_vld_ff;
   logic               x_go;

   // register file valid bits
   logic [31:0]        rf_vld_ff, rf_vld_in;

   // last register and memory writes, for forwarding past the RAM read
   logic               wb_vld_ff;
   logic [4:0]         wb_idx_ff;
   logic [31:0]        wb_val_ff;
   logic               mw_vld_ff;
   logic [DADDR_W-1:0] mw_addr_ff;
   logic [31:0]        mw_val_ff;

   // clearing pass over the data memory
   logic               clr_busy_ff;
   logic [DADDR_W-1:0] clr_cnt_ff;

   // output register
   logic               out_vld_ff, out_vld_in;
   rsp_type            out_ff;

   logic [31:0]        ra_q, rb_q, dm_q;
   logic [31:0]        a_val, b_val, m_val, simm;
   logic [DADDR_W-1:0] x_idx;
   rsp_type            res;
   logic               rw_req, dm_req;
   logic [31:0]        rw_val, dm_wval;
   logic [DADDR_W-1:0] dm_widx;
   logic               rf_we, dm_we;
   logic               ram_we;
   logic [DADDR_W-1:0] ram_waddr;
   logic [31:0]        ram_wdata;

   assign x_go       = x_vld_ff && (!out_vld_ff || rsp_tready);
   assign pop        = head_vld && (!x_vld_ff || x_go);
   assign clr_busy   = clr_busy_ff;
   assign rsp_tvalid = out_vld_ff;
   assign rsp_data   = out_ff;

   // two copies of the register file, one per read port
   mse_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
      .clock   (clock),
      .wr_en   (rf_we),
      .wr_addr (res.reg_index),
      .wr_data (res.reg_value),
      .rd_en   (pop),
      .rd_addr (head.ra),
      .rd_data (ra_q)
   );

   mse_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
      .clock   (clock),
      .wr_en   (rf_we),
      .wr_addr (res.reg_index),
      .wr_data (res.reg_value),
      .rd_en   (pop),
      .rd_addr (head.rb),
      .rd_data (rb_q)
   );

   // data memory, shared with the clearing pass
   assign ram_we    = clr_busy_ff || dm_we;
   assign ram_waddr = clr_busy_ff ? clr_cnt_ff : dm_widx;
   assign ram_wdata = clr_busy_ff ? '0 : dm_wval;

   mse_ram #(.WIDTH(32), .DEPTH(DATA_DEPTH)) u_dmem (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (pop),
      .rd_addr (head.imm[DADDR_W-1:0]),
      .rd_data (dm_q)
   );

   // operand selection: forwarded write, stored word, or reset value
   always_comb begin
      x_idx = x_op_ff.imm[DADDR_W-1:0];
      simm  = {{16{x_op_ff.imm[15]}}, x_op_ff.imm};
      if (wb_vld_ff && wb_idx_ff == x_op_ff.ra) begin
         a_val = wb_val_ff;
      end else if (a_vld_ff) begin
         a_val = ra_q;
      end else begin
         a_val = (x_op_ff.ra == REG_GP) ? gp_init : '0;
      end
      if (wb_vld_ff && wb_idx_ff == x_op_ff.rb) begin
         b_val = wb_val_ff;
      end else if (b_vld_ff) begin
         b_val = rb_q;
      end else begin
         b_val = (x_op_ff.rb == REG_GP) ? gp_init : '0;
      end
      m_val = (mw_vld_ff && mw_addr_ff == x_idx) ? mw_val_ff : dm_q;
   end

   // execute
   always_comb begin
      res     = '0;
      rw_req  = 1'b0;
      rw_val  = '0;
      dm_req  = 1'b0;
      dm_widx = x_idx;
      dm_wval = b_val;
      unique case (x_op_ff.kind)
         K_NOP: begin
         end
         K_ADDU: begin
            rw_req = 1'b1;
            rw_val = a_val + b_val;
         end
         K_SLT: begin
            rw_req = 1'b1;
            rw_val = {31'd0, $signed(a_val) < $signed(b_val)};
         end
         K_ADDIU: begin
            rw_req = 1'b1;
            rw_val = a_val + simm;
         end
         K_LW: begin
            rw_req = 1'b1;
            rw_val = m_val;
         end
         K_SW: begin
            dm_req = 1'b1;
         end
         K_SYS: begin
            priority if (a_val == V0_HALT) begin
               res.halted = 1'b1;
            end else if (a_val == V0_READ) begin
               dm_req  = x_op_ff.mem_ok;
               dm_widx = '0;
               dm_wval = x_op_ff.rd_val;
            end else begin
               res.print_valid = 1'b1;
               res.print_value = a_val;
            end
         end
         K_BAD: begin
            res.bad_index = 1'b1;
         end
      endcase
      // register zero never takes a write
      if (rw_req && x_op_ff.dst != REG_ZERO) begin
         res.reg_written = 1'b1;
         res.reg_index   = x_op_ff.dst;
         res.reg_value   = rw_val;
      end
      res.mem_written = dm_req;
   end

   assign rf_we = x_go && res.reg_written;
   assign dm_we = x_go && res.mem_written;

   // valid bits: set on write, entry 28 dropped back to gp_init on reload
   always_comb begin
      rf_vld_in = rf_vld_ff;
      if (rf_we) begin
         rf_vld_in[res.reg_index] = 1'b1;
      end
      if (gp_wr) begin
         rf_vld_in[REG_GP] = 1'b0;
      end
   end

   always_comb begin
      x_vld_in   = pop || (x_vld_ff && !x_go);
      out_vld_in = x_go || (out_vld_ff && !rsp_tready);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         x_vld_ff    <= 1'b0;
         out_vld_ff  <= 1'b0;
         rf_vld_ff   <= '0;
         wb_vld_ff   <= 1'b0;
         mw_vld_ff   <= 1'b0;
         clr_busy_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else begin
         x_vld_ff   <= x_vld_in;
         out_vld_ff <= out_vld_in;
         rf_vld_ff  <= rf_vld_in;
         if (rf_we) begin
            wb_vld_ff <= 1'b1;
         end else if (gp_wr && wb_idx_ff == REG_GP) begin
            wb_vld_ff <= 1'b0;
         end
         if (dm_we) begin
            mw_vld_ff <= 1'b1;
         end
         if (clr_busy_ff) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == DADDR_W'(DATA_DEPTH - 1)) begin
               clr_busy_ff <= 1'b0;
            end
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (pop) begin
         x_op_ff  <= head;
         a_vld_ff <= rf_vld_ff[head.ra];
         b_vld_ff <= rf_vld_ff[head.rb];
      end
      if (rf_we) begin
         wb_idx_ff <= res.reg_index;
         wb_val_ff <= res.reg_value;
      end
      if (dm_we) begin
         mw_addr_ff <= dm_widx;
         mw_val_ff  <= dm_wval;
      end
      if (x_go) begin
         out_ff <= res;
      end
   end

endmodule

// ----- rtl/mips_subset_execute_unit.sv -----
`timescale 1ns / 1ps
// Throughput: one instruction per cycle while the response is not stalled; the execute
// stage reads both register file ports and the data memory once per instruction, with
// the previous write forwarded.
// Reset: synchronous, active high. Afterwards the data memory is cleared one word a
// cycle, all DATA_DEPTH (1024) words, with req_tready low; the register file reads as
// zero, register 28 as gp_init, until written.

module mips_subset_execute_unit (
   input  logic                       clock,
   input  logic                       reset,
   // request: instruction [31:0], read_value [63:32]
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [mse_pkg::REQ_W-1:0]  req_tdata,
   // response: reg_written [0], reg_index [5:1], reg_value [37:6], mem_written [38],
   // print_valid [39], print_value [71:40], halted [72], bad_index [73], zero [79:74]
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [mse_pkg::RSP_W-1:0]  rsp_tdata,
   // configuration write port
   input  logic                       csr_we,
   input  logic                       csr_addr,
   input  logic [31:0]                csr_wdata
);
   import mse_pkg::*;

   logic [31:0] gp_init_ff;
   logic [10:0] data_words_ff;
   logic        gp_wr;
   logic        head_vld;
   op_type      head;
   logic        pop;
   logic        clr_busy;
   rsp_type     rsp_data;

   // configuration registers
   assign gp_wr = csr_we && csr_addr == CSR_GP_INIT;

   always_ff @(posedge clock) begin
      if (reset) begin
         gp_init_ff    <= '0;
         data_words_ff <= DATA_WORDS_RST;
      end else if (csr_we) begin
         if (csr_addr == CSR_GP_INIT) begin
            gp_init_ff <= csr_wdata;
         end else begin
            data_words_ff <= csr_wdata[10:0];
         end
      end
   end

   mse_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_data   (req_type'(req_tdata)),
      .data_words (data_words_ff),
      .hold_off   (clr_busy),
      .head_vld   (head_vld),
      .head       (head),
      .pop        (pop)
   );

   mse_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_vld   (head_vld),
      .head       (head),
      .pop        (pop),
      .gp_init    (gp_init_ff),
      .gp_wr      (gp_wr),
      .clr_busy   (clr_busy),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_data   (rsp_data)
   );

   assign rsp_tdata = RSP_W'(rsp_data);

endmodule

// ----- rtl/mse_checker.sv -----
`timescale 1ns / 1ps

module mse_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tready,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [mse_pkg::RSP_W-1:0]  rsp_tdata
);
   import mse_pkg::*;

   rsp_type rsp;

   assign rsp = rsp_type'(rsp_tdata[RSP_BITS-1:0]);

   // no requests taken straight after reset, when the data memory is being cleared
   a_clear_after_reset: assert property (@(posedge clock) reset |=> !req_tready)
      else $error("request path open straight after reset");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // an instruction has at most one visible effect
   a_one_effect: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $onehot0({rsp.reg_written, rsp.mem_written, rsp.print_valid,
                               rsp.halted, rsp.bad_index}))
      else $error("more than one effect in one response");

   // register zero is never reported as written
   a_no_r0_write: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp.reg_written |-> rsp.reg_index != REG_ZERO)
      else $error("write to register zero reported");

   // unused register fields are zero
   a_idle_reg_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp.reg_written |-> rsp.reg_index == '0 && rsp.reg_value == '0)
      else $error("register fields set without a register write");

endmodule

bind mips_subset_execute_unit mse_checker u_mse_checker (.*);
